@@ rtl/debounced_key_pulser_defines.svh @@
// ----------------------------------------------------------------------------
// Debounced key pulser assertion macros
// Concurrent check wrappers shared by the RTL; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef DEBOUNCED_KEY_PULSER_DEFINES_SVH
`define DEBOUNCED_KEY_PULSER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset
`define DKP_ASSERT(name, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("dkp check failed");

// Check a property on every clock edge, reset included
`define DKP_ASSERT_ALWAYS(name, prop) \
    name: assert property (@(posedge i_clk) (prop)) \
        else $error("dkp check failed");

`else

`define DKP_ASSERT(name, prop)
`define DKP_ASSERT_ALWAYS(name, prop)

`endif

`endif

@@ rtl/dkp_pkg.sv @@
// ----------------------------------------------------------------------------
// Debounced key pulser package
// Widths, register reset values, register indexes and the per-button
// debounce step.
// ----------------------------------------------------------------------------
package dkp_pkg;

    localparam int unsigned CNT_W      = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned IN_TDATA_W = 8;
    localparam int unsigned OUT_TDATA_W = 8;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [CNT_W-1:0] RST_DEBOUNCE_TICKS = 16'd50;
    localparam logic [CNT_W-1:0] RST_PULSE_LEN_NEXT = 16'd250;
    localparam logic [CNT_W-1:0] RST_PULSE_LEN_VOLD = 16'd1500;
    localparam logic [CNT_W-1:0] RST_COOLDOWN_NEXT  = 16'd4000;
    localparam logic [CNT_W-1:0] RST_COOLDOWN_VOLD  = 16'd2000;
    localparam logic [CNT_W-1:0] RST_BOOT_TICKS     = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_TICKS = 3'd0,
        CFG_PULSE_LEN_NEXT = 3'd1,
        CFG_PULSE_LEN_VOLD = 3'd2,
        CFG_COOLDOWN_NEXT  = 3'd3,
        CFG_COOLDOWN_VOLD  = 3'd4,
        CFG_BOOT_TICKS     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic             last_raw;
        logic             stable;
        logic [CNT_W-1:0] since_change;
        logic [CNT_W-1:0] since_action;
    } t_key_state;

    typedef struct packed {
        t_key_state key;
        logic       fell;
    } t_sample;

    // Advance a count, hold at full scale
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    // Take one raw level into a button's debouncer
    function automatic t_sample sample_key(input t_key_state k, input logic raw,
                                           input logic [CNT_W-1:0] deb);
        t_sample s;
        s.key  = k;
        s.fell = 1'b0;
        if (raw != k.last_raw) begin
            s.key.since_change = '0;
        end
        if ((s.key.since_change > deb) && (raw != k.stable)) begin
            s.key.stable = raw;
            s.fell       = ~raw;
        end
        s.key.last_raw = raw;
        return s;
    endfunction

endpackage

@@ rtl/debounced_key_pulser.sv @@
// ----------------------------------------------------------------------------
// Debounced key pulser
// Two active-low buttons debounced on 1 ms ticks, driving fixed-length
// low pulses on two open-drain key lines with a cooldown per button.
// ----------------------------------------------------------------------------
// Each request on the input stream carries a tick flag and the two raw
// button levels. Each one yields exactly one result request on the output
// stream, with the key line drives and event flags after that tick. A
// request is taken by a single pass of counter and compare logic
// between the state registers and the output register. Its result is
// presented on the next cycle. A new request is accepted on every
// cycle in which the output register is empty or is being drained, so
// requests can follow back to back. Requests without the tick flag
// change nothing. After reset the buttons are ignored for boot_ticks
// ticks, and writing boot_ticks reloads that period. The next button
// wins when both fall on the same tick. The elapsed-time counts
// saturate at 65535. Configuration is always ready and should be
// written while no result is outstanding.
// ----------------------------------------------------------------------------
`include "debounced_key_pulser_defines.svh"

module debounced_key_pulser (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: [0] tick_elapsed, [1] next_raw, [2] btn_vol_down, [7:3] zero
    input  logic [dkp_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    // result stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tdata: [0] track_key_low, [1] voldown_key_low, [2] next_started,
    //        [3] vold_started, [4] press_blocked, [7:5] zero
    output logic [dkp_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [dkp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [dkp_pkg::CNT_W-1:0]             i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [dkp_pkg::CNT_W-1:0] r_debounce_ticks;
    logic [dkp_pkg::CNT_W-1:0] r_pulse_len_next;
    logic [dkp_pkg::CNT_W-1:0] r_pulse_len_vold;
    logic [dkp_pkg::CNT_W-1:0] r_cooldown_next;
    logic [dkp_pkg::CNT_W-1:0] r_cooldown_vold;

    // ------------------------------------------------------------------
    // Working state
    // ------------------------------------------------------------------
    logic [dkp_pkg::CNT_W-1:0] r_boot_left,  n_boot_left;
    logic [dkp_pkg::CNT_W-1:0] r_pulse_left, n_pulse_left;
    logic                      r_pulse_on_track, n_pulse_on_track;
    dkp_pkg::t_key_state       r_key_next, n_key_next;
    dkp_pkg::t_key_state       r_key_vold, n_key_vold;

    // Result register
    logic                      r_out_valid;
    logic                      r_track_low,  n_track_low;
    logic                      r_vold_low,   n_vold_low;
    logic                      r_next_start, n_next_start;
    logic                      r_vold_start, n_vold_start;
    logic                      r_blocked,    n_blocked;

    logic                      in_acc;
    logic                      cfg_acc;
    logic                      boot_wr;
    logic                      tick;
    logic                      raw_next;
    logic                      raw_vold;
    logic [dkp_pkg::CNT_W-1:0] pulse_dec;
    dkp_pkg::t_sample          smp_next;
    dkp_pkg::t_sample          smp_vold;

    // Take a new request whenever the result slot is free or draining
    assign s_axis_tready = ~r_out_valid | m_axis_tready;
    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign cfg_acc       = i_cfg_valid & o_cfg_ready;
    assign boot_wr       = cfg_acc &
                           (dkp_pkg::t_cfg_idx'(i_cfg_index) == dkp_pkg::CFG_BOOT_TICKS);

    assign tick     = s_axis_tdata[0];
    assign raw_next = s_axis_tdata[1];
    assign raw_vold = s_axis_tdata[2];

    assign pulse_dec = r_pulse_left - 1'b1;

    // ------------------------------------------------------------------
    // One tick of state update
    // ------------------------------------------------------------------
    always_comb begin
        n_boot_left      = r_boot_left;
        n_pulse_left     = r_pulse_left;
        n_pulse_on_track = r_pulse_on_track;
        n_key_next       = r_key_next;
        n_key_vold       = r_key_vold;
        n_next_start     = 1'b0;
        n_vold_start     = 1'b0;
        n_blocked        = 1'b0;
        smp_next         = '0;
        smp_vold         = '0;

        if (tick) begin
            // advance all four elapsed-time counts first
            n_key_next.since_change = dkp_pkg::sat_inc(r_key_next.since_change);
            n_key_next.since_action = dkp_pkg::sat_inc(r_key_next.since_action);
            n_key_vold.since_change = dkp_pkg::sat_inc(r_key_vold.since_change);
            n_key_vold.since_action = dkp_pkg::sat_inc(r_key_vold.since_action);

            if (r_boot_left != '0) begin
                n_boot_left = r_boot_left - 1'b1;
            end else if (r_pulse_left != '0) begin
                // run the pulse; on its last tick restart that cooldown
                n_pulse_left = pulse_dec;
                if (pulse_dec == '0) begin
                    if (r_pulse_on_track) begin
                        n_key_next.since_action = '0;
                    end else begin
                        n_key_vold.since_action = '0;
                    end
                end
            end else begin
                smp_next   = dkp_pkg::sample_key(n_key_next, raw_next, r_debounce_ticks);
                n_key_next = smp_next.key;
                if (smp_next.fell) begin
                    if (n_key_next.since_action >= r_cooldown_next) begin
                        n_pulse_left     = (r_pulse_len_next == '0) ? dkp_pkg::CNT_W'(1)
                                                                    : r_pulse_len_next;
                        n_pulse_on_track = 1'b1;
                        n_next_start     = 1'b1;
                    end else begin
                        n_blocked = 1'b1;
                    end
                end
                // a started next pulse leaves volume-down unsampled
                if (!n_next_start) begin
                    smp_vold   = dkp_pkg::sample_key(n_key_vold, raw_vold,
                                                     r_debounce_ticks);
                    n_key_vold = smp_vold.key;
                    if (smp_vold.fell) begin
                        if (n_key_vold.since_action >= r_cooldown_vold) begin
                            n_pulse_left     = (r_pulse_len_vold == '0)
                                               ? dkp_pkg::CNT_W'(1) : r_pulse_len_vold;
                            n_pulse_on_track = 1'b0;
                            n_vold_start     = 1'b1;
                        end else begin
                            n_blocked = 1'b1;
                        end
                    end
                end
            end
        end

        n_track_low = (n_pulse_left != '0) &  n_pulse_on_track;
        n_vold_low  = (n_pulse_left != '0) & ~n_pulse_on_track;
    end

    // ------------------------------------------------------------------
    // Configuration and state registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= dkp_pkg::RST_DEBOUNCE_TICKS;
            r_pulse_len_next <= dkp_pkg::RST_PULSE_LEN_NEXT;
            r_pulse_len_vold <= dkp_pkg::RST_PULSE_LEN_VOLD;
            r_cooldown_next  <= dkp_pkg::RST_COOLDOWN_NEXT;
            r_cooldown_vold  <= dkp_pkg::RST_COOLDOWN_VOLD;
            r_boot_left      <= dkp_pkg::RST_BOOT_TICKS;
            r_pulse_left     <= '0;
            r_pulse_on_track <= 1'b0;
            r_key_next       <= '{last_raw: 1'b1, stable: 1'b1,
                                  since_change: '0, since_action: '0};
            r_key_vold       <= '{last_raw: 1'b1, stable: 1'b1,
                                  since_change: '0, since_action: '0};
        end else begin
            if (in_acc) begin
                r_pulse_left     <= n_pulse_left;
                r_pulse_on_track <= n_pulse_on_track;
                r_key_next       <= n_key_next;
                r_key_vold       <= n_key_vold;
            end
            // a boot_ticks write reloads the ignore period
            if (boot_wr) begin
                r_boot_left <= i_cfg_data;
            end else if (in_acc) begin
                r_boot_left <= n_boot_left;
            end
            // user writes only when idle, unenforced; bad indexes ignored
            if (cfg_acc) begin
                case (dkp_pkg::t_cfg_idx'(i_cfg_index))
                    dkp_pkg::CFG_DEBOUNCE_TICKS: r_debounce_ticks <= i_cfg_data;
                    dkp_pkg::CFG_PULSE_LEN_NEXT: r_pulse_len_next <= i_cfg_data;
                    dkp_pkg::CFG_PULSE_LEN_VOLD: r_pulse_len_vold <= i_cfg_data;
                    dkp_pkg::CFG_COOLDOWN_NEXT:  r_cooldown_next  <= i_cfg_data;
                    dkp_pkg::CFG_COOLDOWN_VOLD:  r_cooldown_vold  <= i_cfg_data;
                    dkp_pkg::CFG_BOOT_TICKS:     ;
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register: hold while stalled, load on every accepted request
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_track_low  <= n_track_low;
            r_vold_low   <= n_vold_low;
            r_next_start <= n_next_start;
            r_vold_start <= n_vold_start;
            r_blocked    <= n_blocked;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_blocked, r_vold_start, r_next_start,
                            r_vold_low, r_track_low};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `DKP_ASSERT(a_one_start, r_out_valid |-> !(r_next_start && r_vold_start))
    `DKP_ASSERT(a_one_line_low, r_out_valid |-> !(r_track_low && r_vold_low))
    `DKP_ASSERT(a_start_drives_line,
                (r_out_valid && r_next_start) |-> r_track_low)
    `DKP_ASSERT(a_pulse_only_on_tick,
                !(in_acc && tick) |=> $stable(r_pulse_left))
    `DKP_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> !r_out_valid)

endmodule
